[design/ellipse_mask_pixel_compositor_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the elliptical mask compositor
// Concurrent check wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_MASK_PIXEL_COMPOSITOR_ASSERT_SVH
`define ELLIPSE_MASK_PIXEL_COMPOSITOR_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define EMC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define EMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define EMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EMC_ASSERT_ALWAYS(label, cond, msg)
`define EMC_ASSERT_SAME(label, ante, cons, msg)
`define EMC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[design/emc_pkg.sv]
// ----------------------------------------------------------------------------
// emc_pkg
// Shared constants and register codes of the elliptical mask compositor.
// ----------------------------------------------------------------------------
package emc_pkg;

  // Default frame dimension; coordinates are clog2 of this wide.
  localparam int MaxDimDefault = 1024;

  // Width of one color component.
  localparam int ColorW = 8;

  // One RGB pixel, red in the lowest byte.
  localparam int PixelW = 3 * ColorW;

  // Width of the configuration register index.
  localparam int CfgIdxW = 4;

  // Cycles from a configuration register update until every derived
  // ellipse value is valid.
  localparam int GeomLat = 6;
  localparam int SettleW = $clog2(GeomLat + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegLeftEyeX    = 4'd0,
    RegLeftEyeY    = 4'd1,
    RegRightEyeX   = 4'd2,
    RegRightEyeY   = 4'd3,
    RegLeftMouthX  = 4'd4,
    RegLeftMouthY  = 4'd5,
    RegRightMouthX = 4'd6,
    RegRightMouthY = 4'd7
  } emc_reg_e;

endpackage

[design/emc_geom.sv]
// ----------------------------------------------------------------------------
// emc_geom
// Landmark registers and the pipeline that derives the ellipse from them.
// ----------------------------------------------------------------------------
module emc_geom import emc_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault,
  localparam int CW = $clog2(MAX_DIM)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,
  output logic [CW-1:0]        xc_o,
  output logic [CW-1:0]        yc_o,
  output logic [2*CW-1:0]      a2_o,
  output logic [2*CW+1:0]      b2_o,
  output logic [4*CW+1:0]      a2b2_o,
  output logic                 nondegen_o
);

  // Division by ten as a multiply by a rounded-up reciprocal; the shift is
  // four bits wider than the dividend, which keeps the quotient exact.
  localparam int NW     = CW + 4;
  localparam int DivS   = NW + 4;
  localparam int DivM   = (2 ** DivS + 9) / 10;
  localparam int DivMW  = $clog2(DivM + 1);
  localparam int DivPW  = NW + DivMW;

  logic [CW-1:0] lex_q, ley_q, rex_q, rey_q, lmx_q, lmy_q, rmx_q, rmy_q;

  // Midpoint as the left value plus the truncated half of the signed distance.
  function automatic logic [CW-1:0] mid_trunc(input logic [CW-1:0] lo,
                                               input logic [CW-1:0] hi);
    logic signed [CW:0] diff;
    logic signed [CW:0] half;
    logic signed [CW:0] sum;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    half = (diff + $signed({{CW{1'b0}}, diff[CW]})) >>> 1;
    sum  = $signed({1'b0, lo}) + half;
    return sum[CW-1:0];
  endfunction

  // Midpoint as the lower value plus half the distance.
  function automatic logic [CW-1:0] mid_low(input logic [CW-1:0] p,
                                            input logic [CW-1:0] q);
    logic [CW-1:0] lo;
    logic [CW-1:0] gap;
    lo  = (q > p) ? p : q;
    gap = (q > p) ? (q - p) : (p - q);
    return lo + {1'b0, gap[CW-1:1]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q <= '0;
      ley_q <= '0;
      rex_q <= '0;
      rey_q <= '0;
      lmx_q <= '0;
      lmy_q <= '0;
      rmx_q <= '0;
      rmy_q <= '0;
    end else if (cfg_wr_i) begin
      case (cfg_index_i)
        RegLeftEyeX:    lex_q <= cfg_data_i;
        RegLeftEyeY:    ley_q <= cfg_data_i;
        RegRightEyeX:   rex_q <= cfg_data_i;
        RegRightEyeY:   rey_q <= cfg_data_i;
        RegLeftMouthX:  lmx_q <= cfg_data_i;
        RegLeftMouthY:  lmy_q <= cfg_data_i;
        RegRightMouthX: rmx_q <= cfg_data_i;
        RegRightMouthY: rmy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: eye span magnitude and the four landmark midpoints.
  logic signed [CW:0] a_d;
  logic [CW-1:0] aabs1_d;
  logic [CW-1:0] aabs1_q, xce1_q, xcm1_q, yce1_q, ycm1_q;

  assign a_d     = $signed({1'b0, rex_q}) - $signed({1'b0, lex_q});
  assign aabs1_d = a_d[CW] ? CW'(-a_d) : a_d[CW-1:0];

  // Stage 2: center and vertical landmark distance.
  logic [CW:0]   xsum_d, ysum_d;
  logic [CW-1:0] dm2_d;
  logic [CW-1:0] xc2_q, yc2_q, dm2_q, aabs2_q;

  assign xsum_d = {1'b0, xce1_q} + {1'b0, xcm1_q};
  assign ysum_d = {1'b0, yce1_q} + {1'b0, ycm1_q};
  assign dm2_d  = (ycm1_q > yce1_q) ? (ycm1_q - yce1_q) : (yce1_q - ycm1_q);

  // Stage 3: thirteen times the distance, and a squared.
  logic [NW-1:0]   n13_d, n13_q;
  logic [2*CW-1:0] a2_3_q;

  assign n13_d = (NW'(dm2_q) << 3) + (NW'(dm2_q) << 2) + NW'(dm2_q);

  // Stage 4: divide by ten.
  logic [DivPW-1:0] quot_prod_d;
  logic [CW:0]      b4_q;
  logic [2*CW-1:0]  a2_4_q;

  assign quot_prod_d = DivPW'(n13_q) * DivPW'(DivM);

  // Stage 5: b squared.
  logic [2*CW+1:0] b2_5_q;
  logic [2*CW-1:0] a2_5_q;

  // Stage 6: right-hand side of the ellipse test.
  logic [4*CW+1:0] a2b2_6_q;
  logic [2*CW+1:0] b2_6_q;
  logic [2*CW-1:0] a2_6_q;
  logic            nondegen_6_q;

  always_ff @(posedge clk_i) begin
    aabs1_q <= aabs1_d;
    xce1_q  <= mid_trunc(lex_q, rex_q);
    xcm1_q  <= mid_trunc(lmx_q, rmx_q);
    yce1_q  <= mid_low(ley_q, rey_q);
    ycm1_q  <= mid_low(lmy_q, rmy_q);

    xc2_q   <= xsum_d[CW:1];
    yc2_q   <= ysum_d[CW:1];
    dm2_q   <= dm2_d;
    aabs2_q <= aabs1_q;

    n13_q   <= n13_d;
    a2_3_q  <= (2*CW)'(aabs2_q) * (2*CW)'(aabs2_q);

    b4_q    <= quot_prod_d[DivS +: CW+1];
    a2_4_q  <= a2_3_q;

    b2_5_q  <= (2*CW+2)'(b4_q) * (2*CW+2)'(b4_q);
    a2_5_q  <= a2_4_q;

    a2b2_6_q     <= (4*CW+2)'(a2_5_q) * (4*CW+2)'(b2_5_q);
    b2_6_q       <= b2_5_q;
    a2_6_q       <= a2_5_q;
    nondegen_6_q <= (a2_5_q != '0) && (b2_5_q != '0);
  end

  assign xc_o       = xc2_q;
  assign yc_o       = yc2_q;
  assign a2_o       = a2_6_q;
  assign b2_o       = b2_6_q;
  assign a2b2_o     = a2b2_6_q;
  assign nondegen_o = nondegen_6_q;

endmodule

[design/ellipse_mask_pixel_compositor.sv]
// ----------------------------------------------------------------------------
// ellipse_mask_pixel_compositor
// Selects the overlay or the base pixel depending on an elliptical face mask.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while the output side is not
// stalled and the geometry has settled, and returns one composited pixel per
// request, in order. Eight landmark registers (both eyes and both mouth
// corners) define the ellipse; the derived center, axes and products are
// computed in a six-stage geometry pipeline, so after reset and after every
// landmark write the input side holds s_axis_tready low while that pipeline
// refills. Landmarks are to be written only while no pixel is in flight; the
// block does not enforce this. A pixel whose row or column is not below
// MAX_DIM, or any pixel when the ellipse collapses (eye span or scaled
// mouth-to-eye distance is zero), takes the base color.
// ----------------------------------------------------------------------------
`include "ellipse_mask_pixel_compositor_assert.svh"

module ellipse_mask_pixel_compositor import emc_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault,
  localparam int CW   = $clog2(MAX_DIM),
  localparam int InW  = 8 * ((2 * CW + 2 * PixelW + 7) / 8)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Landmark register writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,

  // Pixel requests.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, base_red, base_green, base_blue,
  // overlay_red, overlay_green, overlay_blue, zero padding.
  input  logic [InW-1:0]       s_axis_tdata,

  // Composited pixels.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0 up: out_red, out_green, out_blue.
  output logic [PixelW-1:0]    m_axis_tdata,
  // Fields from bit 0 up: inside_ellipse.
  output logic                 m_axis_tuser
);

  localparam int BaseLsb    = 2 * CW;
  localparam int OverlayLsb = 2 * CW + PixelW;

  // --------------------------------------------------------------------------
  // Configuration and ellipse geometry
  // --------------------------------------------------------------------------
  logic            cfg_wr;
  logic [CW-1:0]   geom_xc, geom_yc;
  logic [2*CW-1:0] geom_a2;
  logic [2*CW+1:0] geom_b2;
  logic [4*CW+1:0] geom_a2b2;
  logic            geom_nondegen;

  // Writes are always taken; the contract keeps them out of busy periods.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  emc_geom #(
    .MAX_DIM (MAX_DIM)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .xc_o        (geom_xc),
    .yc_o        (geom_yc),
    .a2_o        (geom_a2),
    .b2_o        (geom_b2),
    .a2b2_o      (geom_a2b2),
    .nondegen_o  (geom_nondegen)
  );

  // The settle counter blocks pixel requests until the geometry pipeline
  // reflects the current landmark registers.
  logic [SettleW-1:0] settle_cnt_d, settle_cnt_q;

  always_comb begin
    settle_cnt_d = settle_cnt_q;
    if (cfg_wr) begin
      settle_cnt_d = SettleW'(GeomLat);
    end else if (settle_cnt_q != '0) begin
      settle_cnt_d = settle_cnt_q - SettleW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_cnt_q <= SettleW'(GeomLat);
    end else begin
      settle_cnt_q <= settle_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline
  // Stage 1 takes the distances to the center, stage 2 squares them,
  // stage 3 scales them by the opposite axis squared, and stage 4 adds,
  // compares against a^2*b^2 and picks the color. Each stage advances when
  // the one after it is empty or moving, so a stall holds everything in place.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_accept;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1 && (settle_cnt_q == '0);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_accept;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Stage 1: absolute offsets from the center and the frame check.
  logic [CW-1:0]       px, py;
  logic signed [CW:0]  dx_d, dy_d;
  logic [CW-1:0]       adx1_d, ady1_d;
  logic                inf1_d;
  logic [CW-1:0]       adx1_q, ady1_q;
  logic                inf1_q;
  logic [PixelW-1:0]   base1_q, ovl1_q;

  assign px     = s_axis_tdata[CW-1:0];
  assign py     = s_axis_tdata[2*CW-1:CW];
  assign dx_d   = $signed({1'b0, px}) - $signed({1'b0, geom_xc});
  assign dy_d   = $signed({1'b0, py}) - $signed({1'b0, geom_yc});
  assign adx1_d = dx_d[CW] ? CW'(-dx_d) : dx_d[CW-1:0];
  assign ady1_d = dy_d[CW] ? CW'(-dy_d) : dy_d[CW-1:0];
  assign inf1_d = ({1'b0, px} < (CW+1)'(MAX_DIM)) && ({1'b0, py} < (CW+1)'(MAX_DIM));

  // Stage 2: squared offsets.
  logic [2*CW-1:0]   dx2_q, dy2_q;
  logic              inf2_q;
  logic [PixelW-1:0] base2_q, ovl2_q;

  // Stage 3: dx^2*b^2 and dy^2*a^2.
  logic [4*CW+1:0]   p1_q;
  logic [4*CW-1:0]   p2_q;
  logic              inf3_q;
  logic [PixelW-1:0] base3_q, ovl3_q;

  // Stage 4: compare and select.
  logic [4*CW+2:0]   lhs_d;
  logic              inside4_d;
  logic [PixelW-1:0] rgb4_d;
  logic [PixelW-1:0] rgb4_q;
  logic              inside4_q;

  assign lhs_d     = (4*CW+3)'(p1_q) + (4*CW+3)'(p2_q);
  assign inside4_d = inf3_q && geom_nondegen && (lhs_d <= (4*CW+3)'(geom_a2b2));
  assign rgb4_d    = inside4_d ? ovl3_q : base3_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_accept) begin
      adx1_q  <= adx1_d;
      ady1_q  <= ady1_d;
      inf1_q  <= inf1_d;
      base1_q <= s_axis_tdata[BaseLsb +: PixelW];
      ovl1_q  <= s_axis_tdata[OverlayLsb +: PixelW];
    end
    if (rdy2 && v1_q) begin
      dx2_q   <= (2*CW)'(adx1_q) * (2*CW)'(adx1_q);
      dy2_q   <= (2*CW)'(ady1_q) * (2*CW)'(ady1_q);
      inf2_q  <= inf1_q;
      base2_q <= base1_q;
      ovl2_q  <= ovl1_q;
    end
    if (rdy3 && v2_q) begin
      p1_q    <= (4*CW+2)'(dx2_q) * (4*CW+2)'(geom_b2);
      p2_q    <= (4*CW)'(dy2_q) * (4*CW)'(geom_a2);
      inf3_q  <= inf2_q;
      base3_q <= base2_q;
      ovl3_q  <= ovl2_q;
    end
    if (rdy4 && v3_q) begin
      rgb4_q    <= rgb4_d;
      inside4_q <= inside4_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = rgb4_q;
  assign m_axis_tuser  = inside4_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `EMC_ASSERT_SAME(a_settle_blocks_input, settle_cnt_q != '0, !s_axis_tready, "open in settle")
  `EMC_ASSERT_NEXT(a_cfg_write_blocks_input, cfg_wr, !s_axis_tready, "open after write")
  `EMC_ASSERT_NEXT(a_accept_fills_stage1, in_accept, v1_q, "accepted pixel lost")
  `EMC_ASSERT_ALWAYS(a_settle_in_range, settle_cnt_q <= SettleW'(GeomLat), "settle out of range")

endmodule
